/* rtl/core/assert_macros.svh */
// assertion macros for the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/mctm_pkg.sv */
// types, constants and codes for the midi clock tempo meter
// no dependencies; used by every module of the block
package mctm_pkg;

  localparam int unsigned PULSES_PER_BEAT_DEF = 24;

  localparam int unsigned CFG_W   = 20;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SUM_W   = 25;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned TEMPO_W = 17;
  localparam int unsigned MEAN_W  = 20;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned DVD_W   = 34;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned IDX_W   = 1;

  localparam logic [STEP_W-1:0] TEMPO_STEPS = STEP_W'(DVD_W);

  localparam logic [CFG_W-1:0]   MIN_INTERVAL_RST = 20'd6000;
  localparam logic [CFG_W-1:0]   MAX_INTERVAL_RST = 20'd70000;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX        = 17'd131071;
  // microseconds per minute times 256
  localparam logic [DVD_W-1:0]   Q8_MINUTE_US     = 34'd15360000000;

  localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
  localparam logic [7:0] BYTE_START    = 8'hFA;
  localparam logic [7:0] BYTE_CONTINUE = 8'hFB;
  localparam logic [7:0] BYTE_STOP     = 8'hFC;

  localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_INTERVAL = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_TEMPO    = 3'd1,
    KIND_START    = 3'd2,
    KIND_CONTINUE = 3'd3,
    KIND_STOP     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_MEAN_LOAD,
    ST_TEMPO_LOAD,
    ST_TEMPO_RUN,
    ST_TEMPO_SAVE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0]        status_byte;
    logic [TIME_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic [TEMPO_W-1:0] tempo_bpm_q8;
    logic [MEAN_W-1:0]  mean_pulse_us;
    logic               running;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    logic  seed;
    logic  diff;
    logic  clear_all;
    logic  cont;
    logic  stop;
    logic  clear_window;
    logic  accum;
    logic  mean_load;
    logic  tempo_load;
    logic  div_step;
    logic  set_warm;
    logic  tempo_save;
    logic  set_kind;
    kind_e kind;
    logic  emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_clock;
    logic is_start;
    logic is_cont;
    logic is_stop;
    logic have_last;
    logic in_window;
    logic beat_full;
    logic warmed;
    logic mean_zero;
  } dp_status_t;

endpackage

/* rtl/core/midi_clock_tempo_meter_core.sv */
// path: a transport, plain or first clock byte passes decode and emit; a later pulse that
// does not end a beat adds the window check; a beat that ends in warm-up or with a zero mean
// adds mean load and tempo load; a tempo beat forms the mean by reciprocal multiply, runs 34
// steps of the serial tempo divider at one quotient bit per cycle and then saves the tempo
// throughput: one item at a time; next accept in the cycle after the result is loaded
// reset: asynchronous, clears measurement and transport state, intervals back to 6000/70000 us
module midi_clock_tempo_meter_core import mctm_pkg::*; #(
  parameter int unsigned PULSES_PER_BEAT = PULSES_PER_BEAT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  mctm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mctm_dp #(
    .PULSES_PER_BEAT (PULSES_PER_BEAT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/core/mctm_dp.sv */
// datapath: measurement state, config registers, mean multiplier, serial tempo divider
// depends on mctm_pkg; driven by mctm_ctrl commands
module mctm_dp import mctm_pkg::*; #(
  parameter int unsigned PULSES_PER_BEAT = PULSES_PER_BEAT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  in_item_t          in_item_i,
  input  ctl_cmd_t          cmd_i,
  output dp_status_t        status_o,
  output out_item_t         out_item_o
);

  localparam logic [CNT_W-1:0] PPB      = CNT_W'(PULSES_PER_BEAT);
  localparam int unsigned      PROD_W   = SUM_W + CNT_W;
  localparam int unsigned      RECIP_SH = SUM_W + CNT_W;
  localparam int unsigned      MPROD_W  = SUM_W + RECIP_SH + 1;
  // ceil(2^30 / pulses) gives the exact floor quotient for every 25-bit sum
  localparam logic [MPROD_W-1:0] RECIP =
    MPROD_W'(((64'd1 << RECIP_SH) + 64'(PULSES_PER_BEAT) - 64'd1) / 64'(PULSES_PER_BEAT));

  logic [CFG_W-1:0]  min_q, max_q;
  logic [7:0]        status_q;
  logic [TIME_W-1:0] time_q, last_q, dt_q;
  logic              have_last_q, warmed_q, running_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  count_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [SUM_W-1:0]  rem_q, dvs_q, mean_q;
  logic [TEMPO_W-1:0] tempo_q;
  kind_e             kind_q;
  out_item_t         out_q;

  logic [SUM_W:0]     rem_sh, rem_sub;
  logic               rem_ge;
  logic [PROD_W-1:0]  prod;
  logic [MPROD_W-1:0] mean_prod;
  logic [CNT_W-1:0]   count_inc;

  // one restoring division step (a quotient bit per cycle), the divisor and mean products, the count increment
  always_comb begin
    rem_sh    = {rem_q, dvd_q[DVD_W-1]};
    rem_ge    = rem_sh >= {1'b0, dvs_q};
    rem_sub   = rem_sh - {1'b0, dvs_q};
    prod      = PROD_W'(mean_q) * PROD_W'(PPB);
    mean_prod = MPROD_W'(sum_q) * RECIP;
    count_inc = count_q + CNT_W'(1);
  end

  always_comb begin
    status_o.is_clock  = status_q == BYTE_CLOCK;
    status_o.is_start  = status_q == BYTE_START;
    status_o.is_cont   = status_q == BYTE_CONTINUE;
    status_o.is_stop   = status_q == BYTE_STOP;
    status_o.have_last = have_last_q;
    status_o.in_window = (dt_q >= TIME_W'(min_q)) && (dt_q <= TIME_W'(max_q));
    status_o.beat_full = count_inc == PPB;
    status_o.warmed    = warmed_q;
    status_o.mean_zero = mean_q == '0;
  end

  // control state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MIN_INTERVAL_RST;
      max_q       <= MAX_INTERVAL_RST;
      have_last_q <= 1'b0;
      warmed_q    <= 1'b0;
      running_q   <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_INTERVAL: min_q <= cfg_wdata_i;
          REG_MAX_INTERVAL: max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.seed) begin
        have_last_q <= 1'b1;
      end
      if (cmd_i.clear_all) begin
        have_last_q <= 1'b0;
        warmed_q    <= 1'b0;
        running_q   <= 1'b1;
        sum_q       <= '0;
        count_q     <= '0;
      end
      if (cmd_i.cont) begin
        have_last_q <= 1'b0;
        running_q   <= 1'b1;
        sum_q       <= '0;
        count_q     <= '0;
      end
      if (cmd_i.stop) begin
        running_q <= 1'b0;
      end
      if (cmd_i.clear_window || cmd_i.mean_load) begin
        sum_q   <= '0;
        count_q <= '0;
      end
      if (cmd_i.accum) begin
        sum_q   <= sum_q + dt_q[SUM_W-1:0];
        count_q <= count_inc;
      end
      if (cmd_i.set_warm) begin
        warmed_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_q <= in_item_i.status_byte;
      time_q   <= in_item_i.timestamp_us;
    end
    if (cmd_i.seed) begin
      last_q <= time_q;
    end
    if (cmd_i.clear_all) begin
      last_q <= '0;
    end
    if (cmd_i.diff) begin
      dt_q   <= time_q - last_q;
      last_q <= time_q;
    end
    if (cmd_i.mean_load) begin
      mean_q <= mean_prod[RECIP_SH +: SUM_W];
    end
    if (cmd_i.tempo_load) begin
      dvd_q <= Q8_MINUTE_US;
      rem_q <= '0;
      dvs_q <= prod[SUM_W-1:0];
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
    end
    if (cmd_i.tempo_save) begin
      tempo_q <= (dvd_q > DVD_W'(TEMPO_MAX)) ? TEMPO_MAX : dvd_q[TEMPO_W-1:0];
    end
    if (cmd_i.set_kind) begin
      kind_q <= cmd_i.kind;
    end
    if (cmd_i.emit) begin
      out_q.event_kind    <= kind_q;
      out_q.tempo_bpm_q8  <= (kind_q == KIND_TEMPO) ? tempo_q : '0;
      out_q.mean_pulse_us <= (kind_q == KIND_TEMPO) ? mean_q[MEAN_W-1:0] : '0;
      out_q.running       <= running_q;
    end
  end

  assign out_item_o = out_q;

endmodule

/* rtl/core/mctm_ctrl.sv */
// controller: sequences decode, window check, mean, the serial tempo division and the output
// depends on mctm_pkg; commands mctm_dp
module mctm_ctrl import mctm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.kind  = KIND_NONE;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d        = ST_EMIT;
        cmd_o.set_kind = 1'b1;
        if (status_i.is_start) begin
          cmd_o.clear_all = 1'b1;
          cmd_o.kind      = KIND_START;
        end else if (status_i.is_cont) begin
          cmd_o.cont = 1'b1;
          cmd_o.kind = KIND_CONTINUE;
        end else if (status_i.is_stop) begin
          cmd_o.stop = 1'b1;
          cmd_o.kind = KIND_STOP;
        end else if (status_i.is_clock) begin
          if (!status_i.have_last) begin
            cmd_o.seed = 1'b1;
          end else begin
            cmd_o.diff     = 1'b1;
            cmd_o.set_kind = 1'b0;
            state_d        = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!status_i.in_window) begin
          cmd_o.clear_window = 1'b1;
          cmd_o.set_kind     = 1'b1;
          state_d            = ST_EMIT;
        end else begin
          cmd_o.accum = 1'b1;
          if (status_i.beat_full) begin
            state_d = ST_MEAN_LOAD;
          end else begin
            cmd_o.set_kind = 1'b1;
            state_d        = ST_EMIT;
          end
        end
      end
      ST_MEAN_LOAD: begin
        cmd_o.mean_load = 1'b1;
        state_d         = ST_TEMPO_LOAD;
      end
      ST_TEMPO_LOAD: begin
        // first beat after start or reset is warm-up only
        if (!status_i.warmed) begin
          cmd_o.set_warm = 1'b1;
          cmd_o.set_kind = 1'b1;
          state_d        = ST_EMIT;
        end else if (status_i.mean_zero) begin
          cmd_o.set_kind = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.tempo_load = 1'b1;
          step_d           = TEMPO_STEPS;
          state_d          = ST_TEMPO_RUN;
        end
      end
      ST_TEMPO_RUN: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_TEMPO_SAVE;
        end
      end
      ST_TEMPO_SAVE: begin
        cmd_o.tempo_save = 1'b1;
        cmd_o.set_kind   = 1'b1;
        cmd_o.kind       = KIND_TEMPO;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        // load the output register once the previous item has left
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/mctm_checker.sv */
// port-level checks for the midi clock tempo meter, bound to the top level
// depends on mctm_pkg and assert_macros.svh
`include "assert_macros.svh"

module mctm_checker import mctm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input out_item_t        out_item_o
);

  logic out_wait;
  logic no_tempo;
  logic fields_zero;
  logic transport;
  logic run_ok;

  assign out_wait    = out_valid_o && !out_ready_i;
  assign no_tempo    = out_valid_o && (out_item_o.event_kind != KIND_TEMPO);
  assign fields_zero = (out_item_o.tempo_bpm_q8 == '0) && (out_item_o.mean_pulse_us == '0);
  assign transport   = out_valid_o &&
                       (out_item_o.event_kind inside {KIND_START, KIND_CONTINUE, KIND_STOP});
  assign run_ok      = out_item_o.running == (out_item_o.event_kind != KIND_STOP);

  // a waiting result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_item_o))

  // one item at a time: no accept in the cycle after an accept
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // tempo and mean are zero unless a tempo is reported
  `ASSERT_IMPL(a_tempo_zero, clk_i, rst_ni, no_tempo, fields_zero)

  // transport events agree with the running flag
  `ASSERT_IMPL(a_running_flag, clk_i, rst_ni, transport, run_ok)

endmodule

bind midi_clock_tempo_meter_core mctm_checker u_mctm_checker (.*);

/* bench/midi_clock_tempo_meter_core_test.sv */
`timescale 1ns / 1ps
// testbench for midi_clock_tempo_meter_core: sends midi byte items, predicts each result
// with a behavioral tempo model kept in step with the window registers, checks every field
// depends on mctm_pkg and the core rtl
module midi_clock_tempo_meter_core_test;
  import mctm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned BEAT_PULSES   = PULSES_PER_BEAT_DEF;
  localparam logic [63:0] Q8_US_PER_MIN = 64'd15360000000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_idx   = REG_MIN_INTERVAL;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  out_item_t        out_item;

  // window registers as the block holds them, and the model's measurement state
  logic [CFG_W-1:0] win_min      = MIN_INTERVAL_RST;
  logic [CFG_W-1:0] win_max      = MAX_INTERVAL_RST;
  logic [31:0]      tp_last_us   = '0;
  logic             tp_have_last = 1'b0;
  logic [SUM_W-1:0] tp_sum       = '0;
  logic [CNT_W-1:0] tp_count     = '0;
  logic             tp_warm      = 1'b0;
  logic             tp_running   = 1'b0;

  out_item_t   tempo_events_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          quiet      = 1'b0;
  logic [31:0] now_us     = '0;

  midi_clock_tempo_meter_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic out_item_t meter_predict(in_item_t it);
    out_item_t        r;
    logic [31:0]      dt;
    logic [SUM_W-1:0] avg;
    logic [63:0]      q;
    r = '0;
    case (it.status_byte)
      BYTE_CLOCK: begin
        if (!tp_have_last) begin
          tp_last_us   = it.timestamp_us;
          tp_have_last = 1'b1;
        end else begin
          dt         = it.timestamp_us - tp_last_us;
          tp_last_us = it.timestamp_us;
          if (dt < 32'(win_min) || dt > 32'(win_max)) begin
            tp_sum   = '0;
            tp_count = '0;
          end else begin
            tp_sum   = tp_sum + SUM_W'(dt);
            tp_count = tp_count + CNT_W'(1);
            if (tp_count >= CNT_W'(BEAT_PULSES)) begin
              avg      = tp_sum / SUM_W'(tp_count);
              tp_sum   = '0;
              tp_count = '0;
              if (!tp_warm) begin
                // first full beat only primes the meter
                tp_warm = 1'b1;
              end else if (avg != '0) begin
                q = Q8_US_PER_MIN / (64'(avg) * 64'(BEAT_PULSES));
                r.event_kind    = KIND_TEMPO;
                r.tempo_bpm_q8  = (q > 64'(TEMPO_MAX)) ? TEMPO_MAX : q[TEMPO_W-1:0];
                r.mean_pulse_us = avg[MEAN_W-1:0];
              end
            end
          end
        end
      end
      BYTE_START: begin
        tp_last_us   = '0;
        tp_have_last = 1'b0;
        tp_sum       = '0;
        tp_count     = '0;
        tp_warm      = 1'b0;
        tp_running   = 1'b1;
        r.event_kind = KIND_START;
      end
      BYTE_CONTINUE: begin
        // warm-up survives a continue
        tp_have_last = 1'b0;
        tp_sum       = '0;
        tp_count     = '0;
        tp_running   = 1'b1;
        r.event_kind = KIND_CONTINUE;
      end
      BYTE_STOP: begin
        tp_running   = 1'b0;
        r.event_kind = KIND_STOP;
      end
      default: ;
    endcase
    r.running = tp_running;
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (tempo_events_due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = tempo_events_due.pop_front();
      if (got.event_kind !== want.event_kind)
        report_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      if (got.tempo_bpm_q8 !== want.tempo_bpm_q8)
        report_field("tempo_bpm_q8", 32'(want.tempo_bpm_q8), 32'(got.tempo_bpm_q8));
      if (got.mean_pulse_us !== want.mean_pulse_us)
        report_field("mean_pulse_us", 32'(want.mean_pulse_us), 32'(got.mean_pulse_us));
      if (got.running !== want.running)
        report_field("running", 32'(want.running), 32'(got.running));
    end
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready) tempo_events_due.push_back(meter_predict(in_item));
    if (out_valid && out_ready) check_result(out_item);
  end

  // result side back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid stays high on return; the caller sends again or drains in the same step
  task automatic send_item(logic [7:0] status, logic [31:0] stamp);
    in_item_t it;
    it.status_byte  = status;
    it.timestamp_us = stamp;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic pulse(logic [31:0] gap_us);
    now_us = now_us + gap_us;
    send_item(BYTE_CLOCK, now_us);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tempo_events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MIN_INTERVAL;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= REG_MAX_INTERVAL;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_min = lo;
    win_max = hi;
    @(posedge clk);
  endtask

  task automatic test_plain_bytes();
    send_item(8'h00, 32'h0000_0000);
    send_item(8'hFF, 32'hFFFF_FFFF);
    send_item(8'hF9, 32'h5555_5555);
    send_item(8'h7F, 32'hAAAA_AAAA);
    send_item(BYTE_STOP, 32'h0000_0000);
    send_item(BYTE_START, 32'h0000_0001);
    send_item(BYTE_START, 32'h0000_0002);
    // first pulse only sets the base, next one wraps past zero
    now_us = 32'hFFFF_F000;
    send_item(BYTE_CLOCK, now_us);
    pulse(6656);
    pulse(0);
    pulse(70000);
    pulse(6000);
    pulse(5999);
    pulse(70001);
    send_item(BYTE_CONTINUE, now_us);
    pulse(20000);
    send_item(BYTE_STOP, now_us);
    pulse(20000);
    send_item(8'hFE, now_us);
    send_item(BYTE_CONTINUE, now_us);
    send_item(BYTE_STOP, now_us);
  endtask

  task automatic test_steady_tempo();
    send_item(BYTE_START, now_us);
    now_us = 32'hFFFF_0000;
    repeat (2 * BEAT_PULSES + 1) pulse(20833);
    repeat (BEAT_PULSES / 2) begin
      pulse(6000);
      pulse(70000);
    end
  endtask

  task automatic test_continue_and_stop();
    send_item(BYTE_CONTINUE, now_us);
    repeat (BEAT_PULSES + 1) pulse(10417);
    // clocks keep being measured while stopped
    send_item(BYTE_STOP, now_us);
    repeat (BEAT_PULSES + 1) pulse(31250);
    send_item(BYTE_START, now_us);
    repeat (BEAT_PULSES + 1) pulse(25000);
  endtask

  task automatic test_window_restart();
    repeat (12) pulse(15000);
    pulse(5999);
    repeat (12) pulse(15000);
    pulse(70001);
    repeat (BEAT_PULSES) pulse(15000);
  endtask

  task automatic test_window_extremes();
    // zero window: beats of zero mean finish silently
    drain_results();
    write_window(CFG_W'(0), CFG_W'(0));
    send_item(BYTE_START, now_us);
    repeat (2 * BEAT_PULSES + 1) pulse(0);
    // one microsecond pulses saturate the tempo
    drain_results();
    write_window(CFG_W'(1), CFG_W'(1));
    send_item(BYTE_START, now_us);
    repeat (2 * BEAT_PULSES + 1) pulse(1);
    drain_results();
    write_window(20'd1000000, 20'hFFFFF);
    send_item(BYTE_START, now_us);
    repeat (BEAT_PULSES + 1) pulse(1000000);
    repeat (BEAT_PULSES) pulse(32'hFFFFF);
    // minimum above maximum rejects everything
    drain_results();
    write_window(20'hFFFFF, CFG_W'(1));
    send_item(BYTE_START, now_us);
    repeat (30) pulse($urandom_range(0, 1100000));
    drain_results();
    write_window(MIN_INTERVAL_RST, MAX_INTERVAL_RST);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned base;
    int unsigned span;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 74) begin
        // well-formed run of pulses inside the window
        base = $urandom_range(win_max, win_min);
        span = win_max - base;
        if (span > 64) span = 64;
        repeat ($urandom_range(1, 80)) pulse(base + $urandom_range(0, span));
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0:       send_item(BYTE_START, now_us);
          1:       send_item(BYTE_CONTINUE, now_us);
          default: send_item(BYTE_STOP, now_us);
        endcase
      end else if (pick < 90) begin
        if (win_min != 0 && $urandom_range(0, 1) == 0) pulse($urandom_range(0, win_min - 1));
        else pulse(win_max + 1 + $urandom_range(0, 100000));
      end else begin
        now_us = $urandom;
        send_item(8'($urandom), now_us);
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] lo;
    random_phase(325);
    drain_results();
    lo = CFG_W'($urandom_range(1, 40000));
    write_window(lo, lo + CFG_W'($urandom_range(0, 80000)));
    random_phase(325);
    drain_results();
    write_window(CFG_W'(1), 20'hFFFFF);
    random_phase(325);
    drain_results();
    lo = CFG_W'($urandom_range(1, 40000));
    write_window(lo, lo + CFG_W'($urandom_range(0, 80000)));
    // no idling on either side in the closing stretch
    quiet = 1'b1;
    random_phase(325);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_bytes();
    test_steady_tempo();
    test_continue_and_stop();
    test_window_restart();
    test_window_extremes();
    test_random_traffic();
    drain_results();
    repeat (70) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
